// File: rtl/u8cyr_pkg.sv
// Shared types, constants and the code point lookup for the UTF-8 Cyrillic to LCD converter.
package u8cyr_pkg;

    localparam int unsigned C_QUEUE_DEPTH = 4;

    localparam logic [7:0] C_LEAD_D0     = 8'hD0;
    localparam logic [7:0] C_LEAD_D1     = 8'hD1;
    localparam logic [7:0] C_QMARK       = 8'h3F;
    localparam logic [7:0] C_NUL         = 8'h00;
    localparam logic [7:0] C_MAX_CHARS_RST = 8'd63;
    localparam logic [7:0] C_ROM_YO_UPPER = 8'h45;
    localparam logic [7:0] C_ROM_YO_LOWER = 8'hB5;
    localparam logic [5:0] C_LOW_YO_UPPER = 6'h01;
    localparam logic [5:0] C_LOW_YO_LOWER = 6'h11;
    localparam logic [5:0] C_LOW_BASE     = 6'h10;

    localparam logic [1:0] C_PEND_NONE = 2'd0;
    localparam logic [1:0] C_PEND_D0   = 2'd1;
    localparam logic [1:0] C_PEND_D1   = 2'd2;

    // Mask bit positions of a queued bundle, in output order.
    localparam int unsigned C_SLOT_PAY0 = 0;
    localparam int unsigned C_SLOT_PAY1 = 1;
    localparam int unsigned C_SLOT_TERM = 2;

    // ROM codes for U+0410..U+044F.
    localparam logic [7:0] C_CYR_ROM [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'h44, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'h43, 8'hAB,
        8'hAC, 8'hAC, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'h64, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hAA, 8'h78, 8'h63, 8'hC0,
        8'hC1, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_word;

    // Up to two payload words and the terminator caused by one input word.
    typedef struct packed {
        logic [2:0] mask;
        logic [7:0] pay0;
        logic [7:0] pay1;
    } t_bundle;

    function automatic logic [7:0] f_map_cyr(input logic lead_d1, input logic [5:0] low6);
        logic [7:0] code;
        code = C_QMARK;
        if (!lead_d1) begin
            if (low6 == C_LOW_YO_UPPER) begin
                code = C_ROM_YO_UPPER;
            end else if (low6 >= C_LOW_BASE) begin
                code = C_CYR_ROM[low6 - C_LOW_BASE];
            end
        end else begin
            if (low6 == C_LOW_YO_LOWER) begin
                code = C_ROM_YO_LOWER;
            end else if (low6 < C_LOW_BASE) begin
                code = C_CYR_ROM[{2'b11, low6[3:0]}];
            end
        end
        return code;
    endfunction

endpackage

// File: rtl/utf8_cyrillic_to_lcd_charset.sv
// Top level of the UTF-8 Cyrillic to LCD character-ROM byte converter.
// Output words pass through the bundle queue, the current-bundle register and the
// output register. Throughput: one input word per cycle; the output side moves one
// word per cycle unless stalled, so a multi-word input word holds the serializer
// until all its words are taken. Input stalls only when the bundle queue is full.
// Reset is synchronous, active low; it clears state and sets max_chars to 63.
module utf8_cyrillic_to_lcd_charset #(
    parameter int unsigned QUEUE_DEPTH = u8cyr_pkg::C_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  u8cyr_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output u8cyr_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data
);
    import u8cyr_pkg::*;

    logic    accept;
    logic    push;
    logic    pop;
    logic    q_empty;
    logic    q_full;
    t_bundle push_bundle;
    t_bundle pop_bundle;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    u8cyr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_word     (i_in_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push),
        .o_bundle      (push_bundle)
    );

    u8cyr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_bundle (pop_bundle),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    u8cyr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bundle    (pop_bundle),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// File: rtl/u8cyr_front.sv
// Front end: accepts input words, tracks the pending lead and the payload count, builds bundles.
module u8cyr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  u8cyr_pkg::t_in_word i_in_word,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    output logic               o_push,
    output u8cyr_pkg::t_bundle o_bundle
);
    import u8cyr_pkg::*;

    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] r_max_chars;

    logic       pend;
    logic       is_cont;
    logic       is_lead;
    logic       fresh;
    logic       eos;
    logic [7:0] b;
    logic       req0;
    logic       req1;
    logic       ok0;
    logic       ok1;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic [7:0] count_a;

    always_comb begin
        b       = i_in_word.in_byte;
        eos     = i_in_word.end_of_string;
        pend    = (r_pending != C_PEND_NONE);
        is_cont = (b[7:6] == 2'b10);
        is_lead = (b == C_LEAD_D0) || (b == C_LEAD_D1);
        fresh   = !(pend && is_cont);

        req0 = pend;
        pay0 = is_cont ? f_map_cyr(r_pending == C_PEND_D1, b[5:0]) : C_QMARK;

        req1      = 1'b0;
        pay1      = C_QMARK;
        n_pending = C_PEND_NONE;
        if (fresh) begin
            if (!b[7]) begin
                req1 = 1'b1;
                pay1 = b;
            end else if (is_lead && !eos) begin
                n_pending = (b == C_LEAD_D0) ? C_PEND_D0 : C_PEND_D1;
            end else begin
                req1 = 1'b1;
            end
        end

        ok0     = req0 && (r_count < r_max_chars);
        count_a = r_count + {7'd0, ok0};
        ok1     = req1 && (count_a < r_max_chars);
        n_count = eos ? 8'd0 : count_a + {7'd0, ok1};

        o_bundle.mask               = '0;
        o_bundle.mask[C_SLOT_PAY0]  = ok0;
        o_bundle.mask[C_SLOT_PAY1]  = ok1;
        o_bundle.mask[C_SLOT_TERM]  = eos;
        o_bundle.pay0               = pay0;
        o_bundle.pay1               = pay1;
        o_push = i_accept && (ok0 || ok1 || eos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= C_PEND_NONE;
            r_count     <= '0;
            r_max_chars <= C_MAX_CHARS_RST;
        end else begin
            if (i_accept) begin
                r_pending <= n_pending;
                r_count   <= n_count;
            end
            if (i_cfg_wr_en) begin
                r_max_chars <= i_cfg_wr_data;
            end
        end
    end

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in_word.end_of_string) |=> (r_pending == C_PEND_NONE && r_count == 8'd0))
        else $error("string end did not clear front state");

    a_pending_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("pending lead holds an unused code");

endmodule

// File: rtl/u8cyr_queue.sv
// Short bundle queue between the front end and the output serializer.
module u8cyr_queue #(
    parameter int unsigned DEPTH = u8cyr_pkg::C_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u8cyr_pkg::t_bundle i_bundle,
    input  logic               i_pop,
    output u8cyr_pkg::t_bundle o_bundle,
    output logic               o_empty,
    output logic               o_full
);
    import u8cyr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty  = (r_count == '0);
    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_bundle = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

// File: rtl/u8cyr_back.sv
// Back end: serializes queued bundles into output words through an output register.
module u8cyr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8cyr_pkg::t_bundle  i_bundle,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output u8cyr_pkg::t_out_word o_out_word
);
    import u8cyr_pkg::*;

    t_bundle   r_cur;
    t_bundle   n_cur;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word sel;
    logic      take;

    always_comb begin
        if (r_cur.mask[C_SLOT_PAY0]) begin
            sel.out_byte = r_cur.pay0;
            sel.last     = 1'b0;
        end else if (r_cur.mask[C_SLOT_PAY1]) begin
            sel.out_byte = r_cur.pay1;
            sel.last     = 1'b0;
        end else begin
            sel.out_byte = C_NUL;
            sel.last     = 1'b1;
        end

        take  = (r_cur.mask != '0) && (!r_out_valid || !i_out_stall);
        n_cur = r_cur;
        if (take) begin
            n_cur.mask = r_cur.mask & (r_cur.mask - 3'd1);
        end
        o_pop = !i_empty && (n_cur.mask == '0);
        if (o_pop) begin
            n_cur = i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= sel;
        end
        r_cur.pay0 <= n_cur.pay0;
        r_cur.pay1 <= n_cur.pay1;
        if (!i_rst_n) begin
            r_cur.mask  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur.mask <= n_cur.mask;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("taken word not presented");

    a_pop_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !take) |-> (r_cur.mask == '0))
        else $error("bundle replaced before it was drained");

endmodule

// File: dv/lcd_charset_checker.sv
// Checker for the UTF-8 Cyrillic to LCD converter: predicts output words and compares them.
module lcd_charset_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  u8cyr_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  u8cyr_pkg::t_out_word i_out_word,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    output int                   o_fail_count,
    output int                   o_outstanding,
    output int                   o_checked_count
);
    import u8cyr_pkg::*;

    localparam logic [7:0]  CONT_LO      = 8'h80;
    localparam logic [7:0]  CONT_HI      = 8'hBF;
    localparam logic [7:0]  ASCII_TOP    = 8'h7F;
    localparam logic [10:0] CP_YO_UPPER  = 11'h401;
    localparam logic [10:0] CP_YO_LOWER  = 11'h451;
    localparam logic [10:0] CP_CYR_FIRST = 11'h410;
    localparam logic [10:0] CP_CYR_LAST  = 11'h44F;

    localparam logic [7:0] LCD_CYRILLIC [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'h44, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'h43, 8'hAB,
        8'hAC, 8'hAC, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'h64, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hAA, 8'h78, 8'h63, 8'hC0,
        8'hC1, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    t_out_word  lcd_words_due[$];
    logic [1:0] lead_held;
    logic [7:0] chars_out;
    logic [7:0] char_limit;
    int         mismatches;
    int         checked;

    function automatic logic [7:0] lcd_code(input logic [1:0] lead, input logic [7:0] cont);
        logic [10:0] cp;
        logic [10:0] idx;
        cp = {(lead == C_PEND_D0) ? 5'h10 : 5'h11, cont[5:0]};
        idx = cp - CP_CYR_FIRST;
        if (cp == CP_YO_UPPER) begin
            return C_ROM_YO_UPPER;
        end else if (cp == CP_YO_LOWER) begin
            return C_ROM_YO_LOWER;
        end else if (cp >= CP_CYR_FIRST && cp <= CP_CYR_LAST) begin
            return LCD_CYRILLIC[idx[5:0]];
        end
        return C_QMARK;
    endfunction

    task automatic put_char(input logic [7:0] code);
        if (chars_out < char_limit) begin
            lcd_words_due.push_back(t_out_word'{out_byte: code, last: 1'b0});
            chars_out++;
        end
    endtask

    task automatic convert_word(input t_in_word w);
        logic [7:0] b;
        logic       fresh;
        logic       is_cont;
        logic [1:0] lead;
        b = w.in_byte;
        fresh = 1'b1;
        is_cont = (b >= CONT_LO && b <= CONT_HI);
        if (lead_held != C_PEND_NONE) begin
            lead = lead_held;
            lead_held = C_PEND_NONE;
            if (is_cont) begin
                put_char(lcd_code(lead, b));
                fresh = 1'b0;
            end else begin
                put_char(C_QMARK);
            end
        end
        if (fresh) begin
            if (b <= ASCII_TOP) begin
                put_char(b);
            end else if ((b == C_LEAD_D0 || b == C_LEAD_D1) && !w.end_of_string) begin
                lead_held = (b == C_LEAD_D0) ? C_PEND_D0 : C_PEND_D1;
            end else begin
                put_char(C_QMARK);
            end
        end
        if (w.end_of_string) begin
            lcd_words_due.push_back(t_out_word'{out_byte: C_NUL, last: 1'b1});
            chars_out = '0;
            lead_held = C_PEND_NONE;
        end
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        checked++;
        if (lcd_words_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual out_byte %h last %b",
                     $time, got.out_byte, got.last);
            mismatches++;
        end else begin
            want = lcd_words_due.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte mismatch, expected %h actual %h",
                         $time, want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %b actual %b",
                         $time, want.last, got.last);
                mismatches++;
            end
        end
    endtask

    initial begin
        mismatches = 0;
        checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lead_held = C_PEND_NONE;
            chars_out = '0;
            char_limit = C_MAX_CHARS_RST;
            lcd_words_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                char_limit = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_word);
            end
            if (i_in_valid && !i_in_stall) begin
                convert_word(i_in_word);
            end
        end
        o_fail_count <= mismatches;
        o_outstanding <= lcd_words_due.size();
        o_checked_count <= checked;
    end

endmodule

// File: dv/testbench.sv
// Testbench top for the UTF-8 Cyrillic to LCD converter: stimulus, flow control and verdict.
module testbench;
    import u8cyr_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int RANDOM_WORDS = 210;

    localparam logic [7:0] DIRECTED [25] = '{
        8'h01, 8'h7F, 8'h80, 8'hFF, 8'hD0, 8'h81, 8'hD1, 8'h91,
        8'hD0, 8'h90, 8'hD1, 8'h8F, 8'hD0, 8'h80, 8'hD1, 8'hBF,
        8'hD0, 8'h41, 8'hD1, 8'hD0, 8'hB0, 8'hC0, 8'h00, 8'hD1,
        8'hD1
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    int fail_count;
    int outstanding;
    int checked_count;
    int cycles = 0;
    int words_sent = 0;
    int cfg_writes = 0;
    bit calm = 1'b1;
    bit hold_req = 1'b0;

    utf8_cyrillic_to_lcd_charset dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_word     (in_word),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_word    (out_word),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    lcd_charset_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_word       (in_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_checked_count (checked_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("[utf8_cyrillic_to_lcd_charset] ERROR");
            $finish;
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    out_stall <= 1'b0;
                end
            end else if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 19);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eos);
        in_valid <= 1'b1;
        in_word <= t_in_word'{in_byte: b, end_of_string: eos};
        do begin
            @(posedge clk);
        end while (in_stall);
        words_sent++;
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_max_chars(input logic [7:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    // ASCII and two-byte Cyrillic characters with raw bytes mixed in; noise_pct sets the share of raw bytes.
    task automatic send_text(input int n_chars, input int noise_pct, input bit gaps);
        logic [7:0] text[$];
        int         r;
        for (int i = 0; i < n_chars; i++) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct) begin
                text.push_back(8'($urandom_range(1, 255)));
            end else if (r < noise_pct + (100 - noise_pct) / 2) begin
                text.push_back(8'($urandom_range(1, 127)));
            end else begin
                text.push_back($urandom_range(0, 1) ? C_LEAD_D1 : C_LEAD_D0);
                text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
        for (int i = 0; i < text.size(); i++) begin
            send_word(text[i], i == text.size() - 1);
            if (gaps) begin
                maybe_gap();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b0;
        for (int i = 0; i < 25; i++) begin
            send_word(DIRECTED[i], i == 24);
            maybe_gap();
        end

        write_max_chars(8'd1);
        repeat (4) send_text($urandom_range(1, 6), 10, 1'b1);
        write_max_chars(8'd0);
        repeat (3) send_text($urandom_range(1, 4), 10, 1'b1);
        write_max_chars(8'd255);
        repeat (3) send_text($urandom_range(4, 10), 20, 1'b1);

        // Long output hold-off while words keep coming, then a full pause.
        write_max_chars(8'($urandom_range(40, 255)));
        hold_req = 1'b1;
        send_text(20, 10, 1'b0);
        drain();

        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 2) == 0) begin
                write_max_chars($urandom_range(0, 1) ? 8'($urandom_range(1, 12))
                                                     : 8'($urandom_range(1, 255)));
            end
            calm = ($urandom_range(0, 3) == 0);
            send_text($urandom_range(1, 12), ($urandom_range(0, 4) == 0) ? 60 : 10, 1'b1);
        end

        calm = 1'b1;
        write_max_chars(C_MAX_CHARS_RST);
        repeat (4) send_text($urandom_range(3, 10), 15, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d input words across %0d max_chars settings; checked %0d output words.",
                 words_sent, cfg_writes, checked_count);
        $display("Covered ASCII, Cyrillic pairs, broken and truncated strings, and a full stall.");
        if (fail_count == 0) begin
            $display("[utf8_cyrillic_to_lcd_charset] OK");
        end else begin
            $display("[utf8_cyrillic_to_lcd_charset] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/u8cyr_pkg.sv
rtl/u8cyr_front.sv
rtl/u8cyr_queue.sv
rtl/u8cyr_back.sv
rtl/utf8_cyrillic_to_lcd_charset.sv
dv/lcd_charset_checker.sv
dv/testbench.sv
